[design/vpq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpq_pkg
// Shared types and constants of the vertex projection and quantization block.
// ----------------------------------------------------------------------------
package vpq_pkg;

    localparam int NUM_COEF   = 9;
    localparam int COEF_W     = 48;
    localparam int PROD_W     = 64;
    localparam int SUM_W      = 66;
    localparam int QBITS      = 16;
    localparam int STEPS      = QBITS;

    localparam logic [15:0] GRID_MAX = 16'd32767;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_VERTEX = 1'b1;

    typedef struct packed {
        logic        op;
        logic [3:0]  coef_index;
        logic signed [47:0] coef_value;
        logic [31:0] vertex_word;
    } req_item_t;

    typedef struct packed {
        logic signed [15:0] grid_x;
        logic signed [15:0] grid_y;
    } rsp_item_t;

    typedef struct packed {
        logic                     valid;
        logic signed [SUM_W-1:0]  cx;
        logic signed [SUM_W-1:0]  cy;
        logic signed [SUM_W-1:0]  cw;
    } sums_t;

endpackage

[design/vpq_affine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpq_affine
// Coefficient store and the two-stage multiply and sum of cx, cy and cw.
// ----------------------------------------------------------------------------
module vpq_affine
    import vpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      en,
    input  logic      accept,
    input  req_item_t req,
    output sums_t     sums
);

    logic signed [COEF_W-1:0] coef_store_reg [NUM_COEF];
    logic signed [PROD_W-1:0] prod_reg [NUM_COEF];
    logic signed [PROD_W-1:0] prod_next [NUM_COEF];
    logic                     vld_a_reg;
    logic                     vld_b_reg;
    logic signed [SUM_W-1:0]  cx_reg, cy_reg, cw_reg;
    logic signed [15:0]       vx, vy;

    assign vx = $signed(req.vertex_word[15:0]);
    assign vy = $signed(req.vertex_word[31:16]);

    always_comb
    begin
        for (int i = 0; i < NUM_COEF; i++)
        begin
            if (i < 2 * 3)
            begin
                // Slots 0..2 scale x, slots 3..5 scale y.
                prod_next[i] = PROD_W'(coef_store_reg[i]) * ((i < 3) ? PROD_W'(vx)
                                                                     : PROD_W'(vy));
            end
            else
            begin
                prod_next[i] = PROD_W'(coef_store_reg[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_store_reg[i] <= '0;
            end
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            if (accept && req.op == OP_LOAD && req.coef_index < 4'(NUM_COEF))
            begin
                coef_store_reg[req.coef_index] <= req.coef_value;
            end
            if (en)
            begin
                vld_a_reg <= accept && req.op == OP_VERTEX;
                vld_b_reg <= vld_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            cx_reg <= SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[3]) + SUM_W'(prod_reg[6]);
            cy_reg <= SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[4]) + SUM_W'(prod_reg[7]);
            cw_reg <= SUM_W'(prod_reg[2]) + SUM_W'(prod_reg[5]) + SUM_W'(prod_reg[8]);
        end
    end

    assign sums.valid = vld_b_reg;
    assign sums.cx    = cx_reg;
    assign sums.cy    = cy_reg;
    assign sums.cw    = cw_reg;

endmodule

[design/vpq_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpq_divider
// Pipelined restoring divider: one quotient bit per stage, rounding and
// saturation to the grid range.
// ----------------------------------------------------------------------------
module vpq_divider
    import vpq_pkg::*;
#(
    parameter int GRID_SCALE_LOG2 = 13,
    parameter int COEF_FRAC_BITS  = 40
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [SUM_W-1:0] c,
    input  logic signed [SUM_W-1:0] w,
    output logic                    out_valid,
    output logic signed [15:0]      grid
);

    localparam int W = 82 + GRID_SCALE_LOG2;

    logic [SUM_W-1:0] cm, wm;
    logic             cneg, wneg, wzero;
    logic [W-1:0]     d;

    logic [W-1:0]       n_reg   [STEPS+1];
    logic [W-1:0]       den_reg [STEPS+1];
    logic [QBITS-1:0]   q_reg   [STEPS+1];
    logic               neg_reg [STEPS+1];
    logic               vld_reg [STEPS+1];
    logic [W-1:0]       n_next  [STEPS];
    logic [QBITS-1:0]   q_next  [STEPS];
    logic [15:0]        mag;
    logic               vld_out_reg;
    logic signed [15:0] grid_reg;

    assign cneg  = c[SUM_W-1];
    assign wneg  = w[SUM_W-1];
    assign cm    = cneg ? SUM_W'(-c) : SUM_W'(c);
    assign wm    = wneg ? SUM_W'(-w) : SUM_W'(w);
    assign wzero = (wm == '0);
    // A zero divisor falls back to the fixed-point unit as divisor.
    assign d     = wzero ? (W'(1) << COEF_FRAC_BITS) : W'(wm);

    always_comb
    begin
        for (int j = 0; j < STEPS; j++)
        begin
            n_next[j] = n_reg[j];
            q_next[j] = q_reg[j];
            if (n_reg[j] >= (den_reg[j] << (STEPS - 1 - j)))
            begin
                n_next[j] = n_reg[j] - (den_reg[j] << (STEPS - 1 - j));
                q_next[j][STEPS - 1 - j] = 1'b1;
            end
        end
    end

    // The top quotient bit flags a result beyond the grid range.
    assign mag = q_reg[STEPS][QBITS-1] ? GRID_MAX : {1'b0, q_reg[STEPS][QBITS-2:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= STEPS; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
            vld_out_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int j = 0; j < STEPS; j++)
            begin
                vld_reg[j+1] <= vld_reg[j];
            end
            vld_out_reg <= vld_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Rounding half away from zero: floor((2n + d) / 2d).
            n_reg[0]   <= (W'(cm) << (GRID_SCALE_LOG2 + 1)) + d;
            den_reg[0] <= d << 1;
            q_reg[0]   <= '0;
            neg_reg[0] <= wzero ? cneg : (cneg ^ wneg);
            for (int j = 0; j < STEPS; j++)
            begin
                n_reg[j+1]   <= n_next[j];
                den_reg[j+1] <= den_reg[j];
                q_reg[j+1]   <= q_next[j];
                neg_reg[j+1] <= neg_reg[j];
            end
            grid_reg <= neg_reg[STEPS] ? $signed(-mag) : $signed(mag);
        end
    end

    assign out_valid = vld_out_reg;
    assign grid      = grid_reg;

endmodule

[design/vertex_project_quantize.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_project_quantize
// Projects packed vertices with nine loaded coefficients and quantizes the
// divided results to a rounded, saturated screen grid.
//
//   Channel | Direction | Handshake          | Payload
//   req     | in        | req_valid/ready    | req_item_t: op, index, coef, vertex
//   rsp     | out       | rsp_valid/ready    | rsp_item_t: grid_x, grid_y
//
// One transaction per cycle is accepted while the output is not stalled;
// a vertex result passes two multiply/sum stages, one setup stage, sixteen
// divider stages and one output register. Loads take effect for the next
// vertex and give no result. Reset clears all coefficients. A stalled
// output holds the whole pipeline in place.
// ----------------------------------------------------------------------------
module vertex_project_quantize
    import vpq_pkg::*;
#(
    parameter int GRID_SCALE_LOG2 = 13,
    parameter int COEF_FRAC_BITS  = 40
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    logic               en;
    logic               accept;
    logic               vld_x;
    logic               vld_y;
    logic signed [15:0] grid_x;
    logic signed [15:0] grid_y;
    sums_t              sums;

    assign en        = !rsp_valid || rsp_ready;
    assign req_ready = en;
    assign accept    = req_valid && en;

    vpq_affine u_affine (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .accept (accept),
        .req    (req),
        .sums   (sums)
    );

    vpq_divider #(
        .GRID_SCALE_LOG2 (GRID_SCALE_LOG2),
        .COEF_FRAC_BITS  (COEF_FRAC_BITS)
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sums.valid),
        .c         (sums.cx),
        .w         (sums.cw),
        .out_valid (vld_x),
        .grid      (grid_x)
    );

    // Both dividers run in lockstep, so their valid bits always agree.
    vpq_divider #(
        .GRID_SCALE_LOG2 (GRID_SCALE_LOG2),
        .COEF_FRAC_BITS  (COEF_FRAC_BITS)
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sums.valid),
        .c         (sums.cy),
        .w         (sums.cw),
        .out_valid (vld_y),
        .grid      (grid_y)
    );

    assign rsp_valid  = vld_x && vld_y;
    assign rsp.grid_x = grid_x;
    assign rsp.grid_y = grid_y;

endmodule
